// ----- design/text_console_writer_core_macros.svh -----
// Assertion macros for the console writer checker.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TCW_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("console writer check failed");

// Next-cycle implication, disabled while reset is high.
`define TCW_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("console writer check failed");

`endif

// ----- design/tcw_pkg.sv -----
// -----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: command codes,
// character codes, reset colour and the controller/datapath interface structs.
// -----------------------------------------------------------------------------
package tcw_pkg;

   localparam int unsigned COLS_DEF = 80;
   localparam int unsigned ROWS_DEF = 25;

   localparam logic [7:0] COLOR_RESET  = 8'd7;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_RETURN  = 8'd13;
   localparam logic [7:0] CHAR_NUL     = 8'd0;
   localparam logic [7:0] CHAR_BLANK   = 8'h20;

   localparam logic [15:0] BLANK_RESET = {COLOR_RESET, CHAR_BLANK};

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_SET   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic cap_en;     // capture the request beat
      logic exec_en;    // perform the single-access part of the command
      logic fill_en;    // write reset blank at the sweep address
      logic copy_en;    // scroll copy step: read one row ahead, write behind
      logic blank_en;   // write blank in text colour at the sweep address
      logic sweep_clr;
      logic sweep_inc;
      logic load_rsp;   // load the response register
   } dp_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    need_scroll;
      logic    copy_last;
      logic    sweep_last;
   } dp_status_type;

endpackage

// ----- design/tcw_dp.sv -----
// -----------------------------------------------------------------------------
// tcw_dp
// Datapath: request and cursor registers, text color, cell store with one
// write and one registered read port, sweep counter and response register.
// -----------------------------------------------------------------------------
module tcw_dp #(
   parameter int unsigned COLS = tcw_pkg::COLS_DEF,
   parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_cmd,
   input  logic [7:0]            req_ch,
   input  logic [6:0]            req_col,
   input  logic [4:0]            req_row,
   input  logic [15:0]           req_cell_req,
   input  logic                  csr_write_en,
   input  logic [7:0]            csr_write_data,
   input  tcw_pkg::dp_ctrl_type  ctrl,
   output tcw_pkg::dp_status_type status,
   output logic [15:0]           rsp_read_data,
   output logic [6:0]            rsp_cursor_col,
   output logic [4:0]            rsp_cursor_row,
   output logic                  rsp_out_of_range
);

   localparam int unsigned CELLS    = COLS * ROWS;
   localparam int unsigned AW       = $clog2(CELLS);
   localparam int unsigned COPY_END = (ROWS - 1) * COLS;

   localparam logic [6:0]    COL_LIM  = 7'(COLS);
   localparam logic [4:0]    ROW_LIM  = 5'(ROWS);
   localparam logic [4:0]    ROW_LAST = 5'(ROWS - 1);
   localparam logic [AW-1:0] ADDR_COLS = AW'(COLS);
   localparam logic [AW-1:0] ADDR_ONE  = AW'(1);
   localparam logic [AW-1:0] ADDR_COPY_END = AW'(COPY_END);
   localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);

   tcw_pkg::cmd_type cmd_ff;
   logic [7:0]       ch_ff;
   logic [6:0]       col_ff;
   logic [4:0]       row_ff;
   logic [15:0]      cell_ff;

   logic [6:0]       cursor_x_ff, cursor_x_in;
   logic [4:0]       cursor_y_ff, cursor_y_in;
   logic [7:0]       color_ff, color_in;
   logic [AW-1:0]    sweep_ff, sweep_in;

   logic [15:0]      mem [0:CELLS-1];
   logic [15:0]      mem_q_ff;

   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [15:0]      mem_wdata;

   logic [AW-1:0]    cur_addr, req_addr;
   logic             on_screen, is_print, wrap, last_row;
   logic [6:0]       x_inc;

   // request capture
   always_ff @(posedge clock) begin
      if (ctrl.cap_en) begin
         cmd_ff  <= tcw_pkg::cmd_type'(req_cmd);
         ch_ff   <= req_ch;
         col_ff  <= req_col;
         row_ff  <= req_row;
         cell_ff <= req_cell_req;
      end
   end

   assign cur_addr  = AW'(cursor_y_ff * COLS + cursor_x_ff);
   assign req_addr  = AW'(row_ff * COLS + col_ff);
   assign on_screen = (col_ff < COL_LIM) && (row_ff < ROW_LIM);
   assign is_print  = (ch_ff != tcw_pkg::CHAR_NEWLINE) && (ch_ff != tcw_pkg::CHAR_RETURN)
                      && (ch_ff != tcw_pkg::CHAR_NUL);
   assign x_inc     = cursor_x_ff + {6'd0, is_print};
   assign wrap      = (ch_ff == tcw_pkg::CHAR_NEWLINE) || (x_inc >= COL_LIM);
   assign last_row  = (cursor_y_ff == ROW_LAST);

   // cursor and color
   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      color_in    = color_ff;
      if (ctrl.exec_en && cmd_ff == tcw_pkg::CMD_PUT) begin
         if (wrap) begin
            cursor_x_in = 7'd0;
            cursor_y_in = last_row ? ROW_LAST : cursor_y_ff + 5'd1;
         end else begin
            cursor_x_in = x_inc;
         end
      end
      if (ctrl.exec_en && cmd_ff == tcw_pkg::CMD_CLEAR) begin
         color_in = tcw_pkg::COLOR_RESET;
      end
      if (csr_write_en) begin
         color_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= 7'd0;
         cursor_y_ff <= 5'd0;
         color_ff    <= tcw_pkg::COLOR_RESET;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         color_ff    <= color_in;
      end
   end

   // sweep counter
   always_comb begin
      sweep_in = sweep_ff;
      if (ctrl.sweep_clr) begin
         sweep_in = '0;
      end else if (ctrl.sweep_inc) begin
         sweep_in = sweep_ff + ADDR_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = tcw_pkg::BLANK_RESET;
      mem_re    = 1'b0;
      mem_raddr = sweep_ff + ADDR_COLS;
      if (ctrl.exec_en) begin
         case (cmd_ff)
            tcw_pkg::CMD_PUT: begin
               mem_we    = is_print;
               mem_waddr = cur_addr;
               mem_wdata = {color_ff, ch_ff};
            end
            tcw_pkg::CMD_SET: begin
               mem_we    = on_screen;
               mem_waddr = req_addr;
               mem_wdata = cell_ff;
            end
            tcw_pkg::CMD_READ: begin
               mem_re    = on_screen;
               mem_raddr = req_addr;
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end
      if (ctrl.fill_en) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = tcw_pkg::BLANK_RESET;
      end
      if (ctrl.copy_en) begin
         // read one row ahead, write the cell fetched last cycle one behind
         mem_re    = (sweep_ff != ADDR_COPY_END);
         mem_raddr = sweep_ff + ADDR_COLS;
         mem_we    = (sweep_ff != '0);
         mem_waddr = sweep_ff - ADDR_ONE;
         mem_wdata = mem_q_ff;
      end
      if (ctrl.blank_en) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = {color_ff, tcw_pkg::CHAR_BLANK};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_raddr];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         rsp_read_data    <= (cmd_ff == tcw_pkg::CMD_READ && on_screen) ? mem_q_ff : 16'd0;
         rsp_cursor_col   <= cursor_x_in;
         rsp_cursor_row   <= cursor_y_in;
         rsp_out_of_range <= (cmd_ff inside {tcw_pkg::CMD_SET, tcw_pkg::CMD_READ})
                             && !on_screen;
      end
   end

   assign status.cmd         = cmd_ff;
   assign status.need_scroll = wrap && last_row;
   assign status.copy_last   = (sweep_ff == ADDR_COPY_END);
   assign status.sweep_last  = (sweep_ff == ADDR_LAST);

endmodule

// ----- design/tcw_ctrl.sv -----
// -----------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences reset fill, command execution, scroll and clear sweeps
// and the response handshake.
// -----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tcw_pkg::dp_status_type status,
   output tcw_pkg::dp_ctrl_type   ctrl
);

   typedef enum logic [7:0] {
      ST_INIT  = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_EXEC  = 8'b0000_0100,
      ST_READ  = 8'b0000_1000,
      ST_COPY  = 8'b0001_0000,
      ST_BLANK = 8'b0010_0000,
      ST_FILL  = 8'b0100_0000,
      ST_HOLD  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      finish, rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_stall = 1'b1;
      finish    = 1'b0;
      case (state_ff)
         ST_INIT: begin
            ctrl.fill_en = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end else begin
               ctrl.sweep_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.cap_en = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctrl.exec_en = 1'b1;
            case (status.cmd)
               tcw_pkg::CMD_PUT: begin
                  if (status.need_scroll) begin
                     ctrl.sweep_clr = 1'b1;
                     state_in       = ST_COPY;
                  end else begin
                     finish = 1'b1;
                  end
               end
               tcw_pkg::CMD_SET: begin
                  finish = 1'b1;
               end
               tcw_pkg::CMD_CLEAR: begin
                  ctrl.sweep_clr = 1'b1;
                  state_in       = ST_FILL;
               end
               tcw_pkg::CMD_READ: begin
                  state_in = ST_READ;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         ST_READ: begin
            finish = 1'b1;
         end
         ST_COPY: begin
            ctrl.copy_en = 1'b1;
            if (status.copy_last) begin
               state_in = ST_BLANK;
            end else begin
               ctrl.sweep_inc = 1'b1;
            end
         end
         ST_BLANK: begin
            ctrl.blank_en = 1'b1;
            if (status.sweep_last) begin
               finish = 1'b1;
            end else begin
               ctrl.sweep_inc = 1'b1;
            end
         end
         ST_FILL: begin
            ctrl.fill_en = 1'b1;
            if (status.sweep_last) begin
               finish = 1'b1;
            end else begin
               ctrl.sweep_inc = 1'b1;
            end
         end
         ST_HOLD: begin
            finish = 1'b1;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      // hand the result to the output register once it is free
      if (finish) begin
         if (rsp_free) begin
            ctrl.load_rsp = 1'b1;
            state_in      = ST_IDLE;
         end else begin
            state_in = ST_HOLD;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/text_console_writer_core.sv -----
// -----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console engine: a COLS x ROWS store of 16-bit cells (character in
// the low byte, color in the high byte) with a cursor, scrolling and clear.
// -----------------------------------------------------------------------------
//
//   channel   direction  handshake            beat contents
//   req       in         req_valid/req_stall  cmd, ch, col, row, cell_req
//   rsp       out        rsp_valid/rsp_stall  read_data, cursor_col/row, out_of_range
//   csr       in         csr_write_en         text color byte (no read-back)
//
// Put character and set cell go through accept and one store access; read
// cell goes through accept, store read and registered data to the response.
// A put that leaves the last row adds a scroll that copies each row up and
// blanks the last row; the store has one write and one read port, so the
// copy moves one cell a cycle. Clear goes through accept, decode, then one
// cell write a cycle. After reset the store is swept to blank in color 7
// with req_stall high; csr writes are taken during that sweep.
// A stalled response holds in the output register; one new request is
// accepted meanwhile and its result waits until the register frees.
// -----------------------------------------------------------------------------
module text_console_writer_core #(
   parameter int unsigned COLS = tcw_pkg::COLS_DEF,
   parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_ch,
   input  logic [6:0]  req_col,
   input  logic [4:0]  req_row,
   input  logic [15:0] req_cell_req,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic        rsp_out_of_range,
   // color register
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data
);

   // command and status between the sequencer and the datapath
   tcw_pkg::dp_ctrl_type   dp_ctrl;
   tcw_pkg::dp_status_type dp_status;

   // Sequencer: owns the handshakes and walks the sweeps for reset fill,
   // clear and scroll.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .ctrl      (dp_ctrl)
   );

   // Datapath: cell store, cursor, color register and response payload.
   tcw_dp #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_ch           (req_ch),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_cell_req     (req_cell_req),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .ctrl             (dp_ctrl),
      .status           (dp_status),
      .rsp_read_data    (rsp_read_data),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

// ----- design/tcw_checker.sv -----
// -----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the console writer, bound to the top level.
// -----------------------------------------------------------------------------
`include "text_console_writer_core_macros.svh"

module tcw_checker #(
   parameter int unsigned COLS = tcw_pkg::COLS_DEF,
   parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_read_data,
   input logic [6:0]  rsp_cursor_col,
   input logic [4:0]  rsp_cursor_row,
   input logic        rsp_out_of_range
);

   localparam logic [6:0] COL_LIM = 7'(COLS);
   localparam logic [4:0] ROW_LIM = 5'(ROWS);

   logic [28:0] rsp_payload;

   assign rsp_payload = {rsp_read_data, rsp_cursor_col, rsp_cursor_row, rsp_out_of_range};

   // stalled response beat holds
   `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   // cursor stays on screen
   `TCW_ASSERT_IMPL(a_col_range, rsp_valid, rsp_cursor_col < COL_LIM)
   `TCW_ASSERT_IMPL(a_row_range, rsp_valid, rsp_cursor_row < ROW_LIM)
   // a flagged access returns no data
   `TCW_ASSERT_IMPL(a_oor_zero, rsp_valid && rsp_out_of_range, rsp_read_data == 16'h0000)
   // the store is being blanked right after reset
   `TCW_ASSERT_IMPL(a_init_stall, $fell(reset), req_stall)

endmodule

bind text_console_writer_core tcw_checker #(
   .COLS (COLS),
   .ROWS (ROWS)
) u_tcw_checker (.*);
